// ===== hdl/mandelbrot_escape_count_8lane_top_assert.svh =====
// Assertion macros for the escape-count block.
`ifndef MANDELBROT_ESCAPE_COUNT_8LANE_TOP_ASSERT_SVH
`define MANDELBROT_ESCAPE_COUNT_8LANE_TOP_ASSERT_SVH
`ifndef ASSERT_OFF
`define MEC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("mec implication check failed");
`define MEC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("mec next-cycle check failed");
`else
`define MEC_ASSERT_IMP(lbl, ante, cons)
`define MEC_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// ===== hdl/mec_pkg.sv =====
package mec_pkg;

  localparam int unsigned LANES     = 8;
  localparam int unsigned LANE_BITS = $clog2(LANES);
  localparam int unsigned FRAC      = 26;
  localparam int unsigned ROW_W     = 12;
  localparam int unsigned GRP_W     = 9;
  localparam int unsigned COL_W     = GRP_W + LANE_BITS;
  localparam int unsigned CNT_W     = 10;
  localparam int unsigned MIN_W     = 28;
  localparam int unsigned STEP_W    = 20;
  localparam int unsigned IN_W      = 24;
  localparam int unsigned OUT_BITS  = ROW_W + GRP_W + LANES * CNT_W;
  localparam int unsigned OUT_W     = ((OUT_BITS + 7) / 8) * 8;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DAT_W = 32;

  localparam logic [63:0] BOUND = 64'd1 << (2 * FRAC + 2);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_X_MIN      = 3'd0,
    REG_X_STEP     = 3'd1,
    REG_Y_MIN      = 3'd2,
    REG_Y_STEP     = 3'd3,
    REG_ITER_LIMIT = 3'd4
  } reg_idx_e;

  typedef struct packed {
    logic load;
    logic mul;
    logic upd;
    logic first;
    logic step;
  } lane_ctrl_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) begin
      r = 32'sh7FFFFFFF;
    end else if (v < -64'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

// ===== hdl/mec_lane.sv =====
module mec_lane (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  mec_pkg::lane_ctrl_t                  ctrl_i,
  input  logic        [mec_pkg::COL_W-1:0]     col_i,
  input  logic signed [mec_pkg::MIN_W-1:0]     x_min_i,
  input  logic        [mec_pkg::STEP_W-1:0]    x_step_i,
  input  logic signed [31:0]                   cim_i,
  output logic                                 live_o,
  output logic        [mec_pkg::CNT_W-1:0]     cnt_o
);

  logic signed [31:0] cre_q, zre_q, zim_q;
  logic signed [63:0] rr_q, ii_q, ri_q;
  logic [mec_pkg::CNT_W-1:0] cnt_q;
  logic live_q;

  logic [31:0]        cprod;
  logic signed [63:0] csum;
  logic [63:0]        mag;
  logic               inb, live_d;
  logic signed [63:0] nre_sum, nim_sum;
  logic signed [31:0] nre, nim;

  assign cprod   = 32'(col_i) * 32'(x_step_i);
  assign csum    = 64'(x_min_i) + $signed({32'd0, cprod});
  assign mag     = 64'(rr_q) + 64'(ii_q);
  assign inb     = mag < mec_pkg::BOUND;
  assign live_d  = live_q && (ctrl_i.first || inb);
  assign nre_sum = ((rr_q - ii_q) >>> mec_pkg::FRAC) + 64'(cre_q);
  assign nim_sum = (ri_q >>> (mec_pkg::FRAC - 1)) + 64'(cim_i);
  assign nre     = mec_pkg::sat32(nre_sum);
  assign nim     = mec_pkg::sat32(nim_sum);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      live_q <= 1'b0;
    end else if (ctrl_i.load) begin
      cnt_q  <= '0;
      live_q <= 1'b1;
    end else if (ctrl_i.upd && live_q && !ctrl_i.first) begin
      live_q <= inb;
      if (inb) begin
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      cre_q <= mec_pkg::sat32(csum);
      zre_q <= mec_pkg::sat32(csum);
      zim_q <= cim_i;
    end else if (ctrl_i.upd && ctrl_i.step && live_d) begin
      zre_q <= nre;
      zim_q <= nim;
    end
    if (ctrl_i.mul) begin
      rr_q <= zre_q * zre_q;
      ii_q <= zim_q * zim_q;
      ri_q <= zre_q * zim_q;
    end
  end

  assign live_o = live_q;
  assign cnt_o  = cnt_q;

endmodule

// ===== hdl/mec_merge.sv =====
module mec_merge (
  input  logic                                              clk_i,
  input  logic                                              rst_ni,
  input  logic                                              push_i,
  input  logic [mec_pkg::ROW_W-1:0]                         row_i,
  input  logic [mec_pkg::GRP_W-1:0]                         grp_i,
  input  logic [mec_pkg::LANES-1:0][mec_pkg::CNT_W-1:0]     cnt_i,
  output logic                                              ready_o,
  output logic                                              m_axis_tvalid,
  input  logic                                              m_axis_tready,
  output logic [mec_pkg::OUT_W-1:0]                         m_axis_tdata
);

  logic valid_q;
  logic [mec_pkg::OUT_BITS-1:0] data_q;

  assign ready_o = !valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (push_i) begin
      valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      data_q <= {cnt_i, grp_i, row_i};
    end
  end

  assign m_axis_tvalid = valid_q;
  assign m_axis_tdata  = mec_pkg::OUT_W'(data_q);

endmodule

// ===== hdl/mandelbrot_escape_count_8lane_top.sv =====
// Channel   Dir  Handshake                      Payload
// s_axis    in   s_axis_tvalid/s_axis_tready    tdata: row, column_group
// m_axis    out  m_axis_tvalid/m_axis_tready    tdata: out_row, out_group, count_0..7
// cfg       in   cfg_valid_i/cfg_ready_o        cfg_index_i, cfg_data_i
// Each group is accepted, loaded, iterated and handed off in turn; each
// iteration is a multiply state and an update state in all eight lanes,
// and iteration stops at iter_limit or when all lanes escape. Reset
// restores the register defaults. A stalled output holds the next group
// in its hand-off state, and no new group is accepted meanwhile.
`include "mandelbrot_escape_count_8lane_top_assert.svh"
module mandelbrot_escape_count_8lane_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [mec_pkg::IN_W-1:0]          s_axis_tdata,  // row, column_group
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [mec_pkg::OUT_W-1:0]         m_axis_tdata,  // out_row, out_group, count_0..7
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [mec_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [mec_pkg::CFG_DAT_W-1:0]     cfg_data_i
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_LOAD, ST_MUL, ST_UPD, ST_DONE
  } state_e;

  state_e state_q;
  logic signed [mec_pkg::MIN_W-1:0]  x_min_q, y_min_q;
  logic        [mec_pkg::STEP_W-1:0] x_step_q, y_step_q;
  logic        [mec_pkg::CNT_W-1:0]  limit_q, it_q;
  logic        [mec_pkg::ROW_W-1:0]  row_q;
  logic        [mec_pkg::GRP_W-1:0]  grp_q;
  logic signed [31:0]                cim_q;

  logic [mec_pkg::ROW_W-1:0] in_row;
  logic [mec_pkg::GRP_W-1:0] in_grp;
  logic [31:0]               yprod;
  logic signed [63:0]        ysum;
  logic                      in_acc, push, merge_ready, any_live;
  mec_pkg::lane_ctrl_t       ctrl;
  logic [mec_pkg::LANES-1:0]                       live;
  logic [mec_pkg::LANES-1:0][mec_pkg::CNT_W-1:0]   cnt;

  assign in_row        = s_axis_tdata[mec_pkg::ROW_W-1:0];
  assign in_grp        = s_axis_tdata[mec_pkg::ROW_W +: mec_pkg::GRP_W];
  assign yprod         = 32'(in_row) * 32'(y_step_q);
  assign ysum          = 64'(y_min_q) + $signed({32'd0, yprod});
  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;
  assign any_live      = |live;
  assign push          = (state_q == ST_DONE) && merge_ready;

  assign ctrl.load  = (state_q == ST_LOAD);
  assign ctrl.mul   = (state_q == ST_MUL);
  assign ctrl.upd   = (state_q == ST_UPD);
  assign ctrl.first = (it_q == '0);
  assign ctrl.step  = (it_q != limit_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_min_q  <= -28'sd117440512;
      x_step_q <= 20'd40960;
      y_min_q  <= -28'sd83886080;
      y_step_q <= 20'd40960;
      limit_q  <= 10'd500;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        mec_pkg::REG_X_MIN:      x_min_q  <= cfg_data_i[mec_pkg::MIN_W-1:0];
        mec_pkg::REG_X_STEP:     x_step_q <= cfg_data_i[mec_pkg::STEP_W-1:0];
        mec_pkg::REG_Y_MIN:      y_min_q  <= cfg_data_i[mec_pkg::MIN_W-1:0];
        mec_pkg::REG_Y_STEP:     y_step_q <= cfg_data_i[mec_pkg::STEP_W-1:0];
        mec_pkg::REG_ITER_LIMIT: limit_q  <= cfg_data_i[mec_pkg::CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      it_q    <= '0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            state_q <= ST_LOAD;
          end
        end
        ST_LOAD: begin
          it_q    <= '0;
          state_q <= ST_MUL;
        end
        ST_MUL: begin
          state_q <= any_live ? ST_UPD : ST_DONE;
        end
        ST_UPD: begin
          if (it_q == limit_q) begin
            state_q <= ST_DONE;
          end else begin
            it_q    <= it_q + 1'b1;
            state_q <= ST_MUL;
          end
        end
        ST_DONE: begin
          if (merge_ready) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      row_q <= in_row;
      grp_q <= in_grp;
      cim_q <= mec_pkg::sat32(ysum);
    end
  end

  for (genvar k = 0; k < mec_pkg::LANES; k++) begin : g_lane
    mec_lane u_lane (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctrl_i   (ctrl),
      .col_i    ({grp_q, mec_pkg::LANE_BITS'(k)}),
      .x_min_i  (x_min_q),
      .x_step_i (x_step_q),
      .cim_i    (cim_q),
      .live_o   (live[k]),
      .cnt_o    (cnt[k])
    );
  end

  mec_merge u_merge (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (push),
    .row_i         (row_q),
    .grp_i         (grp_q),
    .cnt_i         (cnt),
    .ready_o       (merge_ready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  `MEC_ASSERT_NXT(a_busy_after_accept, in_acc, !s_axis_tready)
  `MEC_ASSERT_IMP(a_iter_bounded, state_q == ST_UPD, it_q <= limit_q)
  `MEC_ASSERT_NXT(a_push_shows, push, m_axis_tvalid)

endmodule

// ===== tb/sv/mandelbrot_escape_count_8lane_top_tb.sv =====
`timescale 1ns / 100ps

module mandelbrot_escape_count_8lane_top_tb;

  localparam int unsigned CYCLE_LIMIT = 4000000;

  class escape_scoreboard;
    longint x_min, y_min;
    longint x_step, y_step;
    int unsigned iter_limit;
    logic [mec_pkg::OUT_W-1:0] pending_q[$];
    int unsigned mismatches;

    function new();
      x_min = -117440512;
      x_step = 40960;
      y_min = -83886080;
      y_step = 40960;
      iter_limit = 500;
      mismatches = 0;
    endfunction

    function void write_reg(mec_pkg::reg_idx_e idx, logic [mec_pkg::CFG_DAT_W-1:0] d);
      case (idx)
        mec_pkg::REG_X_MIN: x_min = $signed(d[mec_pkg::MIN_W-1:0]);
        mec_pkg::REG_X_STEP: x_step = d[mec_pkg::STEP_W-1:0];
        mec_pkg::REG_Y_MIN: y_min = $signed(d[mec_pkg::MIN_W-1:0]);
        mec_pkg::REG_Y_STEP: y_step = d[mec_pkg::STEP_W-1:0];
        mec_pkg::REG_ITER_LIMIT: iter_limit = d[mec_pkg::CNT_W-1:0];
        default: ;
      endcase
    endfunction

    function longint clamp32(longint v);
      longint r;
      r = v;
      if (v > 64'sd2147483647) r = 64'sd2147483647;
      if (v < -64'sd2147483648) r = -64'sd2147483648;
      return r;
    endfunction

    function void note_input(logic [mec_pkg::ROW_W-1:0] row, logic [mec_pkg::GRP_W-1:0] grp);
      longint c_im, nre, nim;
      longint c_re[mec_pkg::LANES], z_re[mec_pkg::LANES], z_im[mec_pkg::LANES];
      longint unsigned mag;
      bit live[mec_pkg::LANES];
      bit any;
      logic [mec_pkg::CNT_W-1:0] cnt[mec_pkg::LANES];
      logic [mec_pkg::OUT_W-1:0] w;
      c_im = clamp32(y_min + longint'(row) * y_step);
      for (int k = 0; k < mec_pkg::LANES; k++) begin
        c_re[k] = clamp32(x_min + longint'({grp, 3'(k)}) * x_step);
        z_re[k] = c_re[k];
        z_im[k] = c_im;
        cnt[k] = '0;
        live[k] = 1'b1;
      end
      for (int unsigned it = 0; it < iter_limit; it++) begin
        any = 1'b0;
        for (int k = 0; k < mec_pkg::LANES; k++) begin
          if (live[k]) begin
            nre = clamp32(((z_re[k] * z_re[k] - z_im[k] * z_im[k]) >>> mec_pkg::FRAC)
                          + c_re[k]);
            nim = clamp32(((z_re[k] * z_im[k]) >>> (mec_pkg::FRAC - 1)) + c_im);
            z_re[k] = nre;
            z_im[k] = nim;
            mag = longint'(nre * nre) + longint'(nim * nim);
            if (mag < mec_pkg::BOUND) begin
              cnt[k]++;
              any = 1'b1;
            end else begin
              live[k] = 1'b0;
            end
          end
        end
        if (!any) break;
      end
      w = '0;
      w[mec_pkg::ROW_W-1:0] = row;
      w[mec_pkg::ROW_W+mec_pkg::GRP_W-1:mec_pkg::ROW_W] = grp;
      for (int k = 0; k < mec_pkg::LANES; k++)
        w[mec_pkg::ROW_W+mec_pkg::GRP_W+k*mec_pkg::CNT_W +: mec_pkg::CNT_W] = cnt[k];
      pending_q.push_back(w);
    endfunction

    function void check_result(logic [mec_pkg::OUT_W-1:0] got);
      logic [mec_pkg::OUT_W-1:0] want;
      bit bad;
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word %h", got);
        return;
      end
      want = pending_q.pop_front();
      bad = (got[mec_pkg::ROW_W-1:0] !== want[mec_pkg::ROW_W-1:0]) ||
            (got[mec_pkg::ROW_W+mec_pkg::GRP_W-1:mec_pkg::ROW_W] !==
             want[mec_pkg::ROW_W+mec_pkg::GRP_W-1:mec_pkg::ROW_W]);
      for (int k = 0; k < mec_pkg::LANES; k++)
        if (got[mec_pkg::ROW_W+mec_pkg::GRP_W+k*mec_pkg::CNT_W +: mec_pkg::CNT_W] !==
            want[mec_pkg::ROW_W+mec_pkg::GRP_W+k*mec_pkg::CNT_W +: mec_pkg::CNT_W])
          bad = 1'b1;
      if (bad) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("mismatch row/grp exp %0d/%0d got %0d/%0d",
                   want[mec_pkg::ROW_W-1:0],
                   want[mec_pkg::ROW_W+mec_pkg::GRP_W-1:mec_pkg::ROW_W],
                   got[mec_pkg::ROW_W-1:0],
                   got[mec_pkg::ROW_W+mec_pkg::GRP_W-1:mec_pkg::ROW_W]);
          for (int k = 0; k < mec_pkg::LANES; k++)
            $display("  count_%0d exp %0d got %0d", k,
                     want[mec_pkg::ROW_W+mec_pkg::GRP_W+k*mec_pkg::CNT_W +: mec_pkg::CNT_W],
                     got[mec_pkg::ROW_W+mec_pkg::GRP_W+k*mec_pkg::CNT_W +: mec_pkg::CNT_W]);
        end
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [mec_pkg::IN_W-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [mec_pkg::OUT_W-1:0] m_axis_tdata;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [mec_pkg::CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [mec_pkg::CFG_DAT_W-1:0] cfg_data_i = '0;

  escape_scoreboard sb = new();
  int unsigned cycles = 0;
  int unsigned burst_left = 0;
  int unsigned stall_mode = 0;

  mandelbrot_escape_count_8lane_top i_dut (.*);

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // receiver: checks each accepted word; stall behavior is redrawn periodically
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
      if (cycles % 128 == 0) stall_mode = $urandom_range(0, 3);
      case (stall_mode)
        0: m_axis_tready <= 1'b1;
        1: m_axis_tready <= ($urandom_range(0, 3) != 0);
        2: m_axis_tready <= ((cycles % 64) > 40);
        default: m_axis_tready <= $urandom_range(0, 1);
      endcase
    end
  end

  task automatic write_cfg(mec_pkg::reg_idx_e idx, logic [mec_pkg::CFG_DAT_W-1:0] d);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= d;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.write_reg(idx, d);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic send_word(logic [mec_pkg::ROW_W-1:0] row, logic [mec_pkg::GRP_W-1:0] grp);
    if (burst_left == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 5) == 0) ? 60 : $urandom_range(1, 16);
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {3'b000, grp, row};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_input(row, grp);
  endtask

  task automatic set_all(logic [31:0] xm, logic [31:0] xs, logic [31:0] ym,
                         logic [31:0] ys, logic [31:0] il);
    write_cfg(mec_pkg::REG_X_MIN, xm);
    write_cfg(mec_pkg::REG_X_STEP, xs);
    write_cfg(mec_pkg::REG_Y_MIN, ym);
    write_cfg(mec_pkg::REG_Y_STEP, ys);
    write_cfg(mec_pkg::REG_ITER_LIMIT, il);
  endtask

  task automatic random_words(int n);
    for (int i = 0; i < n; i++) begin
      if (i == n / 2) drain();
      send_word($urandom_range(0, 4095), $urandom_range(0, 511));
    end
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // defaults: corners of the image and beyond
    send_word(0, 0);
    send_word(12'hFFF, 9'h1FF);
    send_word(0, 9'h1FF);
    send_word(12'hFFF, 0);
    send_word(2048, 256);
    send_word(12'hAAA, 9'h155);
    send_word(12'h555, 9'h0AA);
    send_word(1024, 96);
    drain();
    // unknown indexes are ignored
    write_cfg(mec_pkg::reg_idx_e'(3'd5), 32'hFFFFFFFF);
    write_cfg(mec_pkg::reg_idx_e'(3'd6), 32'h0);
    write_cfg(mec_pkg::reg_idx_e'(3'd7), 32'h12345678);
    send_word(2048, 300);
    drain();
    // zero iteration limit
    set_all(32'h0, 32'h0, 32'h0, 32'h0, 32'h400);
    send_word(0, 0);
    send_word(12'hFFF, 9'h1FF);
    drain();
    // extremes with saturation
    set_all(32'hF8000000, 32'hFFFFF, 32'h07FFFFFF, 32'hFFFFF, 1023);
    send_word(0, 0);
    send_word(12'hFFF, 9'h1FF);
    send_word(1, 1);
    drain();
    set_all(32'h08000000, 32'h0, 32'h08000000, 32'h0, 1);
    send_word(7, 3);
    send_word(12'hFFF, 9'h1FF);
    drain();
    // near the set interior, full iteration count
    set_all(-50331648, 16, 0, 16, 1023);
    random_words(24);
    drain();
    set_all(-117440512, 40960, -83886080, 40960, 500);
    random_words(150);
    drain();
    for (int p = 0; p < 5; p++) begin
      set_all($urandom, $urandom, $urandom, $urandom, $urandom_range(1, 120));
      random_words(120);
      drain();
    end
    set_all(-134217728, 20480, -67108864, 10240, $urandom_range(1, 60));
    random_words(60);
    drain();
    repeat (50) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
